// ----- design/lpe_pkg.sv -----
package lpe_pkg;

  // Digit width of the shared multiplier: one digit of the direction per cycle
  localparam int unsigned DIG_W = 16;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for a point word
    ST_LOAD,   // set up multiplier operands for one term
    ST_MUL,    // digit-serial multiply
    ST_ACC,    // fold product into dot product, norm or foot
    ST_FSUM,   // add origin and saturate one foot coordinate
    ST_DABS,   // magnitude of the dot product, degenerate check
    ST_DPREP,  // build the rounded dividend
    ST_DCHK,   // zero direction / quotient overflow check
    ST_DIV,    // restoring division, one quotient bit per cycle
    ST_UPD,    // min/max update
    ST_EMIT    // hand the endpoints to the output register
  } state_e;

  // Which product the shared multiplier is working on
  typedef enum logic [1:0] {
    PH_NUM,
    PH_DEN,
    PH_FOOT
  } phase_e;

endpackage

// ----- design/line_projection_extent.sv -----
// Line projection extent. Six config registers (origin x/y/z, direction x/y/z, signed
// fixed point with FRAC_BITS fraction bits) describe a 3D line. Each input word is a
// point; it is projected onto the line (k = dot(p - origin, dir) / |dir|^2 rounded to
// nearest, foot = origin + k * dir rounded half away from zero and saturated), and the
// feet with the least and greatest x are kept, ties keeping the earlier point. A word
// with last_point set produces one output word with both endpoints and clears the
// tracker; degenerate flags an all-zero direction, in which case both feet are the
// origin. One point occupies the block from accept to the next ready; that time is set
// by the single multiplier, which takes one 16-bit digit of the direction per cycle,
// ND = ceil(COORD_WIDTH/16) digits, for nine products, and by the restoring divider,
// which makes one quotient bit per cycle. A zero direction or a quotient beyond the
// saturation range skips the divider. A last point also waits until the output
// register is free. A new point is accepted while a finished result waits at the output.
module line_projection_extent
  import lpe_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  // point input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] pt_x_i,
  input  logic signed [COORD_WIDTH-1:0] pt_y_i,
  input  logic signed [COORD_WIDTH-1:0] pt_z_i,
  input  logic                          last_point_i,
  // endpoint output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] min_end_x_o,
  output logic signed [COORD_WIDTH-1:0] min_end_y_o,
  output logic signed [COORD_WIDTH-1:0] min_end_z_o,
  output logic signed [COORD_WIDTH-1:0] max_end_x_o,
  output logic signed [COORD_WIDTH-1:0] max_end_y_o,
  output logic signed [COORD_WIDTH-1:0] max_end_z_o,
  output logic                          degenerate_o
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int QW   = W + F + 2;              // quotient bits kept
  localparam int ND   = (W + DIG_W - 1) / DIG_W; // direction digits
  localparam int MBW  = ND * DIG_W;
  localparam int AW   = QW;                     // wide multiplier operand
  localparam int PW   = AW + MBW;               // product accumulator
  localparam int NUMW = 2 * W + 2;              // signed dot product
  localparam int DW   = 2 * W;                  // squared norm
  localparam int NW   = 2 * W + F + 2;          // rounded dividend
  localparam int TW   = PW - F;                 // rounded foot offset
  localparam int SW   = TW + 2;                 // offset plus origin
  localparam int CNTW = $clog2(QW);

  localparam logic [1:0] LAST_AXIS = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [W-1:0] org_q [3];
  logic [W-1:0] dir_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= W'(1) << F;  // 1.0
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ORG_X: org_q[0] <= cfg_wdata_i;
        REG_ORG_Y: org_q[1] <= cfg_wdata_i;
        REG_ORG_Z: org_q[2] <= cfg_wdata_i;
        REG_DIR_X: dir_q[0] <= cfg_wdata_i;
        REG_DIR_Y: dir_q[1] <= cfg_wdata_i;
        REG_DIR_Z: dir_q[2] <= cfg_wdata_i;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  state_e            state_q, state_d;
  phase_e            phase_q;
  logic [1:0]        idx_q;
  logic [CNTW-1:0]   cnt_q;
  logic              seen_q;
  logic              out_valid_q;

  // Datapath registers
  logic [W-1:0]      pt_q [3];
  logic              last_q;
  logic [AW-1:0]     ma_q;
  logic [MBW-1:0]    mb_q;
  logic              neg_q;
  logic [PW-1:0]     acc_q;
  logic [NUMW-1:0]   num_q;
  logic [DW-1:0]     den_q;
  logic [NUMW-2:0]   nmag_q;
  logic              kneg_q;
  logic              degen_q;
  logic [DW-1:0]     rem_q;
  logic [QW-1:0]     quo_q;
  logic [TW-1:0]     tr_q;
  logic [W-1:0]      ft_q [3];
  logic [W-1:0]      lo_q [3];
  logic [W-1:0]      hi_q [3];
  logic [W-1:0]      omin_q [3];
  logic [W-1:0]      omax_q [3];
  logic              odeg_q;

  logic in_fire, out_free, emit_fire;

  // --------------------------------------------------------------------------
  // Operand selection for the current axis
  logic [W-1:0] org_sel, dir_sel, pt_sel;
  logic [W:0]   diff, diff_mag;
  logic [W-1:0] dir_mag;

  assign org_sel  = org_q[idx_q];
  assign dir_sel  = dir_q[idx_q];
  assign pt_sel   = pt_q[idx_q];
  assign diff     = {pt_sel[W-1], pt_sel} - {org_sel[W-1], org_sel};
  assign diff_mag = diff[W] ? (~diff + 1'b1) : diff;
  assign dir_mag  = dir_sel[W-1] ? (~dir_sel + 1'b1) : dir_sel;

  // Shared multiplier: wide operand times one direction digit, MSB digit first
  logic [AW+DIG_W-1:0] prod;
  logic [PW-1:0]       acc_next;

  assign prod     = {{DIG_W{1'b0}}, ma_q} * {{AW{1'b0}}, mb_q[MBW-1 -: DIG_W]};
  assign acc_next = {acc_q[PW-DIG_W-1:0], {DIG_W{1'b0}}} + PW'(prod);

  // Product folded into the dot product
  logic [NUMW-1:0] term;
  assign term = neg_q ? (~NUMW'(acc_q) + 1'b1) : NUMW'(acc_q);

  // Foot offset rounding, half away from zero on the magnitude
  logic [PW-1:0] acc_rnd;
  assign acc_rnd = acc_q + (PW'(1) << (F - 1));

  // Origin plus signed offset, then saturate to W bits
  logic [SW-1:0] s_org, s_tr, s_sum;
  logic [W-1:0]  s_sat;
  logic          s_fits;

  assign s_org  = {{(SW-W){org_sel[W-1]}}, org_sel};
  assign s_tr   = {2'b00, tr_q};
  assign s_sum  = neg_q ? (s_org - s_tr) : (s_org + s_tr);
  assign s_fits = (s_sum[SW-1:W-1] == '0) || (s_sum[SW-1:W-1] == '1);
  assign s_sat  = s_fits ? s_sum[W-1:0]
                : (s_sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

  // Magnitude of the dot product; it always fits one bit narrower
  logic [NUMW-1:0] num_abs;
  assign num_abs = num_q[NUMW-1] ? (~num_q + 1'b1) : num_q;

  // Dividend: |num| << F plus half the divisor
  logic [NW-1:0] dvd;
  assign dvd = NW'({nmag_q, {F{1'b0}}}) + NW'(den_q >> 1);

  // One restoring division step
  logic [DW:0] rr;
  logic        rr_ge;
  logic [DW:0] rr_sub;
  assign rr     = {rem_q, quo_q[QW-1]};
  assign rr_ge  = rr >= {1'b0, den_q};
  assign rr_sub = rr - {1'b0, den_q};

  logic div_ovf;
  assign div_ovf = rem_q >= den_q;

  // Min/max tracking on the new foot
  logic take_lo, take_hi;
  assign take_lo = !seen_q || ($signed(ft_q[0]) < $signed(lo_q[0]));
  assign take_hi = !seen_q || ($signed(ft_q[0]) > $signed(hi_q[0]));

  // --------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_MUL;
      ST_MUL:   if (cnt_q == '0) state_d = ST_ACC;
      ST_ACC: begin
        if (phase_q == PH_FOOT) begin
          state_d = ST_FSUM;
        end else if (phase_q == PH_DEN && idx_q == LAST_AXIS) begin
          state_d = ST_DABS;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_FSUM:  state_d = (idx_q == LAST_AXIS) ? ST_UPD : ST_LOAD;
      ST_DABS:  state_d = ST_DPREP;
      ST_DPREP: state_d = ST_DCHK;
      ST_DCHK:  state_d = (degen_q || div_ovf) ? ST_LOAD : ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_LOAD;
      ST_UPD:   state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_fire    = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
    emit_fire  = (state_q == ST_EMIT) && out_free;
  end

  // --------------------------------------------------------------------------
  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_NUM;
      idx_q       <= '0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          phase_q <= PH_NUM;
          idx_q   <= '0;
        end
        ST_LOAD: cnt_q <= CNTW'(ND - 1);
        ST_MUL:  cnt_q <= cnt_q - 1'b1;
        ST_ACC: begin
          if (phase_q == PH_NUM) begin
            phase_q <= PH_DEN;
          end else if (phase_q == PH_DEN && idx_q != LAST_AXIS) begin
            phase_q <= PH_NUM;
            idx_q   <= idx_q + 1'b1;
          end
        end
        ST_FSUM: idx_q <= idx_q + 1'b1;
        ST_DCHK: begin
          phase_q <= PH_FOOT;
          idx_q   <= '0;
          cnt_q   <= CNTW'(QW - 1);
        end
        ST_DIV:  cnt_q <= cnt_q - 1'b1;
        ST_UPD:  seen_q <= 1'b1;
        default: ;
      endcase
      if (emit_fire) begin
        seen_q <= 1'b0;
      end
      // output register
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pt_q[0] <= pt_x_i;
          pt_q[1] <= pt_y_i;
          pt_q[2] <= pt_z_i;
          last_q  <= last_point_i;
          num_q   <= '0;
          den_q   <= '0;
        end
      end
      ST_LOAD: begin
        case (phase_q)
          PH_NUM: begin
            ma_q  <= AW'(diff_mag);
            neg_q <= diff[W] ^ dir_sel[W-1];
          end
          PH_DEN: begin
            ma_q  <= AW'(dir_mag);
            neg_q <= 1'b0;
          end
          default: begin
            ma_q  <= quo_q;
            neg_q <= kneg_q ^ dir_sel[W-1];
          end
        endcase
        mb_q  <= MBW'(dir_mag);
        acc_q <= '0;
      end
      ST_MUL: begin
        acc_q <= acc_next;
        mb_q  <= mb_q << DIG_W;
      end
      ST_ACC: begin
        case (phase_q)
          PH_NUM:  num_q <= num_q + term;
          PH_DEN:  den_q <= den_q + DW'(acc_q);
          default: tr_q  <= acc_rnd[PW-1:F];
        endcase
      end
      ST_FSUM: ft_q[idx_q] <= s_sat;
      ST_DABS: begin
        degen_q <= (den_q == '0);
        kneg_q  <= num_q[NUMW-1];
        nmag_q  <= num_abs[NUMW-2:0];
      end
      ST_DPREP: begin
        rem_q <= DW'(dvd[NW-1:QW]);
        quo_q <= dvd[QW-1:0];
      end
      ST_DCHK: begin
        // zero direction projects onto the origin; an oversized quotient saturates
        if (degen_q) begin
          quo_q <= '0;
        end else if (div_ovf) begin
          quo_q <= '1;
        end
      end
      ST_DIV: begin
        rem_q <= rr_ge ? rr_sub[DW-1:0] : rr[DW-1:0];
        quo_q <= {quo_q[QW-2:0], rr_ge};
      end
      ST_UPD: begin
        if (take_lo) begin
          lo_q[0] <= ft_q[0];
          lo_q[1] <= ft_q[1];
          lo_q[2] <= ft_q[2];
        end
        if (take_hi) begin
          hi_q[0] <= ft_q[0];
          hi_q[1] <= ft_q[1];
          hi_q[2] <= ft_q[2];
        end
      end
      default: ;
    endcase
    if (emit_fire) begin
      omin_q[0] <= lo_q[0];
      omin_q[1] <= lo_q[1];
      omin_q[2] <= lo_q[2];
      omax_q[0] <= hi_q[0];
      omax_q[1] <= hi_q[1];
      omax_q[2] <= hi_q[2];
      odeg_q    <= degen_q;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  assign out_valid_o  = out_valid_q;
  assign min_end_x_o  = omin_q[0];
  assign min_end_y_o  = omin_q[1];
  assign min_end_z_o  = omin_q[2];
  assign max_end_x_o  = omax_q[0];
  assign max_end_y_o  = omax_q[1];
  assign max_end_z_o  = omax_q[2];
  assign degenerate_o = odeg_q;

endmodule

// ----- design/lpe_sva.sv -----
module lpe_sva #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic [COORD_WIDTH-1:0] pt_x_i,
  input logic [COORD_WIDTH-1:0] pt_y_i,
  input logic [COORD_WIDTH-1:0] pt_z_i,
  input logic                   last_point_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] min_end_x_o,
  input logic [COORD_WIDTH-1:0] min_end_y_o,
  input logic [COORD_WIDTH-1:0] min_end_z_o,
  input logic [COORD_WIDTH-1:0] max_end_x_o,
  input logic [COORD_WIDTH-1:0] max_end_y_o,
  input logic [COORD_WIDTH-1:0] max_end_z_o,
  input logic                   degenerate_o
);

  // A waiting input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(pt_x_i) && $stable(pt_y_i)
      && $stable(pt_z_i) && $stable(last_point_i))
    else $error("input word changed before accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_end_x_o)
      && $stable(min_end_y_o) && $stable(min_end_z_o) && $stable(max_end_x_o)
      && $stable(max_end_y_o) && $stable(max_end_z_o) && $stable(degenerate_o))
    else $error("output word changed while stalled");

  // A point keeps the block busy: no word accepted on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a point is in progress");

  // A new result only comes out of a point in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a point in progress");

endmodule

bind line_projection_extent lpe_sva #(.COORD_WIDTH(COORD_WIDTH)) u_lpe_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .pt_x_i       (pt_x_i),
  .pt_y_i       (pt_y_i),
  .pt_z_i       (pt_z_i),
  .last_point_i (last_point_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .min_end_x_o  (min_end_x_o),
  .min_end_y_o  (min_end_y_o),
  .min_end_z_o  (min_end_z_o),
  .max_end_x_o  (max_end_x_o),
  .max_end_y_o  (max_end_y_o),
  .max_end_z_o  (max_end_z_o),
  .degenerate_o (degenerate_o)
);
